// ===== rtl/core/kaef_pkg.sv =====
`default_nettype none
package kaef_pkg;

  localparam logic [1:0] OP_SCAN     = 2'd0;
  localparam logic [1:0] OP_POP      = 2'd1;
  localparam logic [1:0] OP_FLUSH    = 2'd2;
  localparam logic [1:0] OP_PUSHBACK = 2'd3;

  localparam logic [1:0] REG_FIRST_DELAY   = 2'd0;
  localparam logic [1:0] REG_INTERVAL      = 2'd1;
  localparam logic [1:0] REG_RELEASE_DELAY = 2'd2;

  localparam logic [14:0] FIRST_DELAY_RST   = 15'd400;
  localparam logic [14:0] INTERVAL_RST      = 15'd100;
  localparam logic [14:0] RELEASE_DELAY_RST = 15'd50;

  localparam logic [7:0] RELEASE_FLAG = 8'h80;

  typedef struct packed {
    logic       push;
    logic [7:0] code;
    logic       advance;
    logic       flush;
  } ring_ctl_t;

  typedef struct packed {
    logic       empty;
    logic [7:0] head;
    logic [3:0] count;
  } ring_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/kaef_ring.sv =====
`default_nettype none
module kaef_ring #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kaef_pkg::ring_ctl_t  ctl,
  output kaef_pkg::ring_sts_t       sts
);
  import kaef_pkg::*;

  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic [7:0]    mem [RING_DEPTH];
  logic [7:0]    head_q;
  logic [RW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [RW-1:0] wr_inc, rd_inc;
  logic          full;
  logic [RW:0]   diff;
  logic [RW+3:0] diff_ext;

  assign wr_inc = (wr_r == RW'(RING_DEPTH - 1)) ? '0 : wr_r + RW'(1);
  assign rd_inc = (rd_r == RW'(RING_DEPTH - 1)) ? '0 : rd_r + RW'(1);
  assign full   = (wr_inc == rd_r);

  always_comb begin
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (ctl.push && !full) begin
      wr_nxt = wr_inc;
    end
    if (ctl.flush) begin
      rd_nxt = wr_r;
    end else if (ctl.advance) begin
      rd_nxt = rd_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      mem[wr_r] <= ctl.code;
    end
    head_q <= mem[rd_r];
  end

  always_comb begin
    if (wr_r >= rd_r) begin
      diff = {1'b0, wr_r} - {1'b0, rd_r};
    end else begin
      diff = {1'b0, wr_r} + (RW+1)'(RING_DEPTH) - {1'b0, rd_r};
    end
    diff_ext = {3'b000, diff};
  end

  assign sts.empty = (wr_r == rd_r);
  assign sts.head  = head_q;
  assign sts.count = diff_ext[3:0];

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && full) |=> $stable(wr_r))
    else $error("push into a full ring moved the write pointer");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && !ctl.flush) |-> (wr_r != rd_r))
    else $error("read pointer advanced on an empty ring");

endmodule
`default_nettype wire

// ===== rtl/core/keypad_autorepeat_event_fifo_top.sv =====
`default_nettype none
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | tuser op, tdata buttons, time_ms, pushback_code
// out     | out | out_tvalid / out_tready| tdata event_code, pressed_map, buffered_count
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// a scan request sweeps the keys in turn: one key memory read and at most one ring write per key
// a pop served from the ring passes through S_POP (ring memory read) to S_DONE; other requests go straight to S_DONE
// one request at a time; the next is taken once the result sits in the output register
// output register stalls only the final step when a result is still waiting
// synchronous reset clears key flags, pointers and push-back slot; memories are not cleared
module keypad_autorepeat_event_fifo_top #(
  parameter int NUM_KEYS   = 8,
  parameter int RING_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // buttons[7:0], time_ms[23:8], pushback_code[31:24]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // event_code[7:0], pressed_map[15:8], buffered_count[19:16]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  import kaef_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(NUM_KEYS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic elapsed(input logic [15:0] now, input logic [15:0] stamp,
                                   input logic [14:0] lim);
    logic [15:0] d;
    d = now - stamp;
    return !d[15] && (d[14:0] >= lim);
  endfunction

  logic [14:0] first_delay_r, interval_r, release_delay_r;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NUM_KEYS-1:0] held_r, held_nxt;
  logic [7:0]    pb_r, pb_nxt;
  logic [7:0]    ev_r, ev_nxt;
  logic [NUM_KEYS-1:0] btn_r;
  logic [15:0]   now_r;

  logic          out_valid_r;
  logic [23:0]   out_data_r;

  logic [31:0]   kmem [NUM_KEYS];
  logic [31:0]   key_q;
  logic [KW-1:0] key_ra;
  logic          key_we;
  logic [31:0]   key_wd;

  ring_ctl_t     rctl;
  ring_sts_t     rsts;

  logic          in_acc;
  logic [CW-1:0] pk_full;
  logic [KW-1:0] pk;
  logic          down, held;
  logic [15:0]   nrt_old, nrt_new;
  logic [7:0]    code;
  logic [7:0]    map8;
  logic          out_free;

  logic [NUM_KEYS-1:0] btn_in;
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_btn
    if (g < 8) begin : g_on
      assign btn_in[g] = in_tdata[g];
    end else begin : g_off
      assign btn_in[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_map
    if (g < NUM_KEYS) begin : g_on
      assign map8[g] = held_r[g];
    end else begin : g_off
      assign map8[g] = 1'b0;
    end
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r   <= FIRST_DELAY_RST;
      interval_r      <= INTERVAL_RST;
      release_delay_r <= RELEASE_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST_DELAY:   first_delay_r   <= cfg_data;
        REG_INTERVAL:      interval_r      <= cfg_data;
        REG_RELEASE_DELAY: release_delay_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign pk_full = cnt_r - CW'(1);
  assign pk      = pk_full[KW-1:0];
  assign down    = btn_r[pk];
  assign held    = held_r[pk];
  assign nrt_old = key_q[31:16];
  assign code    = 8'((32'(pk) + 32'd1) & 32'h7F);
  assign nrt_new = now_r + {1'b0, first_delay_r} - {1'b0, interval_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    held_nxt  = held_r;
    pb_nxt    = pb_r;
    ev_nxt    = ev_r;
    key_ra    = '0;
    key_we    = 1'b0;
    key_wd    = {nrt_old, now_r};
    rctl      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ev_nxt = 8'h00;
          unique case (in_tuser)
            OP_SCAN: begin
              cnt_nxt   = CW'(1);
              state_nxt = S_SCAN;
            end
            OP_POP: begin
              if (pb_r != 8'h00) begin
                ev_nxt    = pb_r;
                pb_nxt    = 8'h00;
                state_nxt = S_DONE;
              end else if (rsts.empty) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_POP;
              end
            end
            OP_FLUSH: begin
              rctl.flush = 1'b1;
              pb_nxt     = 8'h00;
              state_nxt  = S_DONE;
            end
            OP_PUSHBACK: begin
              pb_nxt    = in_tdata[31:24];
              state_nxt = S_DONE;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        key_ra = cnt_r[KW-1:0];
        if (down) begin
          key_we = 1'b1;
          if (!held) begin
            key_wd       = {nrt_new, now_r};
            held_nxt[pk] = 1'b1;
            rctl.push    = 1'b1;
            rctl.code    = code;
          end else if (elapsed(now_r, nrt_old, interval_r)) begin
            key_wd    = {now_r, now_r};
            rctl.push = 1'b1;
            rctl.code = code;
          end
        end else if (held && elapsed(now_r, key_q[15:0], release_delay_r)) begin
          held_nxt[pk] = 1'b0;
          rctl.push    = 1'b1;
          rctl.code    = code | RELEASE_FLAG;
        end
        if (cnt_r == CW'(NUM_KEYS)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_POP: begin
        ev_nxt       = rsts.head;
        rctl.advance = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      held_r      <= '0;
      pb_r        <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      held_r  <= held_nxt;
      pb_r    <= pb_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
    if (in_acc) begin
      btn_r <= btn_in;
      now_r <= in_tdata[23:8];
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {4'h0, rsts.count, map8, ev_r};
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      kmem[pk] <= key_wd;
    end
    key_q <= kmem[key_ra];
  end

  kaef_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (rctl),
    .sts  (rsts)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == OP_SCAN) |=> (state_r == S_SCAN && cnt_r == CW'(1)))
    else $error("scan request did not start the key sweep");

  a_pop_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (!rsts.empty && pb_r == 8'h00))
    else $error("ring pop with push-back pending or empty ring");

  a_scan_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (state_r == S_SCAN || state_r == S_DONE))
    else $error("key sweep left to an unexpected state");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> (out_tvalid && state_r == S_IDLE))
    else $error("finished request did not reach the output register");

endmodule
`default_nettype wire

// ===== test/keypad_autorepeat_event_fifo_top_tb.sv =====
`default_nettype none
module keypad_autorepeat_event_fifo_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kaef_pkg::*;

  localparam int DIR_N = 24;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] map;
    logic [3:0] count;
  } kp_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  btn;
    logic [15:0] tms;
    logic [7:0]  pb;
    bit          typed;
    kp_result_t  res;
  } kp_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // buttons[7:0], time_ms[23:8], pushback_code[31:24]
  logic [1:0]  in_tuser = '0;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // event_code[7:0], pressed_map[15:8], buffered_count[19:16]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  keypad_autorepeat_event_fifo_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // keypad state mirror
  logic [14:0] first_dly = FIRST_DELAY_RST;
  logic [14:0] rep_int = INTERVAL_RST;
  logic [14:0] rel_dly = RELEASE_DELAY_RST;
  logic [7:0]  key_held = '0;
  logic [15:0] key_next_rep [8];
  logic [15:0] key_last_down [8];
  logic [7:0]  ring_mem [16];
  logic [3:0]  ring_wr = '0;
  logic [3:0]  ring_rd = '0;
  logic [7:0]  pb_slot = '0;

  kp_result_t pending_results [$];
  kp_row_t    dir_tab [DIR_N];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         snd_idle = 20;
  int         rcv_idle = 79;
  bit         long_hold_req = 1'b0;
  int         hold_left = 0;
  logic [15:0] scan_time;
  logic [7:0]  scan_btn = '0;

  function automatic bit time_passed(input logic [15:0] now, input logic [15:0] stamp,
                                     input logic [14:0] lim);
    logic [15:0] d;
    d = now - stamp;
    return !d[15] && (d >= {1'b0, lim});
  endfunction

  function automatic void ring_push(input logic [7:0] code);
    logic [3:0] nxt;
    nxt = ring_wr + 4'd1;
    if (nxt != ring_rd) begin
      ring_mem[ring_wr] = code;
      ring_wr = nxt;
    end
  endfunction

  function automatic kp_result_t keypad_step(input logic [1:0] op, input logic [7:0] btn,
                                             input logic [15:0] tms, input logic [7:0] pb);
    kp_result_t r;
    logic [7:0] code;
    r = '0;
    case (op)
      OP_SCAN: begin
        for (int i = 0; i < 8; i++) begin
          code = 8'(i + 1);
          if (btn[i]) begin
            if (!key_held[i]) begin
              key_next_rep[i] = tms + {1'b0, first_dly} - {1'b0, rep_int};
              key_held[i] = 1'b1;
              ring_push(code);
            end else if (time_passed(tms, key_next_rep[i], rep_int)) begin
              key_next_rep[i] = tms;
              ring_push(code);
            end
            key_last_down[i] = tms;
          end else if (key_held[i] && time_passed(tms, key_last_down[i], rel_dly)) begin
            key_held[i] = 1'b0;
            ring_push(code | RELEASE_FLAG);
          end
        end
      end
      OP_POP: begin
        if (pb_slot != 8'h00) begin
          r.code = pb_slot;
          pb_slot = 8'h00;
        end else if (ring_rd != ring_wr) begin
          r.code = ring_mem[ring_rd];
          ring_rd = ring_rd + 4'd1;
        end
      end
      OP_FLUSH: begin
        ring_rd = ring_wr;
        pb_slot = 8'h00;
      end
      default: pb_slot = pb;
    endcase
    r.map = key_held;
    r.count = ring_wr - ring_rd;
    return r;
  endfunction

  task automatic offer_req(input logic [1:0] op, input logic [7:0] btn, input logic [15:0] tms,
                           input logic [7:0] pb, input bit typed, input kp_result_t typed_res);
    kp_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {pb, tms, btn};
    do @(posedge clk); while (!in_tready);
    predicted = keypad_step(op, btn, tms, pb);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FIRST_DELAY:   first_dly = data;
      REG_INTERVAL:      rep_int = data;
      REG_RELEASE_DELAY: rel_dly = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [14:0] fd, input logic [14:0] ri, input logic [14:0] rd,
                            input bit bad_index);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_FIRST_DELAY, fd);
    write_reg(REG_INTERVAL, ri);
    write_reg(REG_RELEASE_DELAY, rd);
    if (bad_index) write_reg(REG_NONE, 15'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly plausible key activity over advancing time, plus pops, push-backs, flushes and noise
  task automatic run_random(input int n, input bit with_hold);
    int r;
    logic [1:0]  op;
    logic [7:0]  btn;
    logic [15:0] tms;
    logic [7:0]  pb;
    for (int k = 0; k < n; k++) begin
      if (k == n / 4) idle_until_drained();
      if (with_hold && k == n / 2) long_hold_req = 1'b1;
      r = $urandom_range(99);
      btn = 8'($urandom);
      tms = 16'($urandom);
      pb = 8'($urandom);
      if (r < 55) begin
        op = OP_SCAN;
        if ($urandom_range(9) == 0) scan_btn = 8'($urandom);
        else if ($urandom_range(2) == 0) scan_btn ^= 8'(1 << $urandom_range(7));
        case ($urandom_range(19))
          0: ;
          1: scan_time += 16'($urandom_range(32767, 1000));
          default: scan_time += 16'($urandom_range(40, 1));
        endcase
        btn = scan_btn;
        tms = scan_time;
      end else if (r < 85) begin
        op = OP_POP;
      end else if (r < 90) begin
        op = OP_PUSHBACK;
        if ($urandom_range(3) == 0) pb = 8'h00;
      end else if (r < 93) begin
        op = OP_FLUSH;
      end else begin
        op = OP_SCAN;
      end
      offer_req(op, btn, tms, pb, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    kp_result_t got;
    kp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.code = out_tdata[7:0];
      got.map = out_tdata[15:8];
      got.count = out_tdata[19:16];
      if (pending_results.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: code %h map %h count %0d", got.code, got.map, got.count);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.code !== want.code || got.map !== want.map || got.count !== want.count) begin
          if (mismatch_cnt < 10)
            $display("mismatch: code %h/%h map %h/%h count %0d/%0d (exp/act)",
                     want.code, got.code, want.map, got.map, want.count, got.count);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    scan_time = 16'($urandom);
    dir_tab[0]  = '{OP_POP,      8'h00, 16'h0000, 8'h00, 1'b1, '{8'h00, 8'h00, 4'd0}};
    dir_tab[1]  = '{OP_FLUSH,    8'h00, 16'h0000, 8'h00, 1'b1, '{8'h00, 8'h00, 4'd0}};
    dir_tab[2]  = '{OP_SCAN,     8'h00, 16'h0000, 8'h00, 1'b1, '{8'h00, 8'h00, 4'd0}};
    dir_tab[3]  = '{OP_SCAN,     8'hFF, 16'h0000, 8'h00, 1'b1, '{8'h00, 8'hFF, 4'd8}};
    dir_tab[4]  = '{OP_POP,      8'h00, 16'h0000, 8'h00, 1'b1, '{8'h01, 8'hFF, 4'd7}};
    dir_tab[5]  = '{OP_PUSHBACK, 8'h00, 16'h0000, 8'hFF, 1'b1, '{8'h00, 8'hFF, 4'd7}};
    dir_tab[6]  = '{OP_POP,      8'h00, 16'h0000, 8'h00, 1'b1, '{8'hFF, 8'hFF, 4'd7}};
    dir_tab[7]  = '{OP_PUSHBACK, 8'h00, 16'h0000, 8'h00, 1'b1, '{8'h00, 8'hFF, 4'd7}};
    dir_tab[8]  = '{OP_POP,      8'h00, 16'h0000, 8'h00, 1'b1, '{8'h02, 8'hFF, 4'd6}};
    // just before and at the first repeat, then ring overflow
    dir_tab[9]  = '{OP_SCAN,     8'hFF, 16'd399,  8'h00, 1'b0, '0};
    dir_tab[10] = '{OP_SCAN,     8'hFF, 16'd400,  8'h00, 1'b0, '0};
    dir_tab[11] = '{OP_SCAN,     8'hFF, 16'd500,  8'h00, 1'b0, '0};
    dir_tab[12] = '{OP_FLUSH,    8'h00, 16'h0000, 8'h00, 1'b1, '{8'h00, 8'hFF, 4'd0}};
    dir_tab[13] = '{OP_POP,      8'h00, 16'h0000, 8'h00, 1'b1, '{8'h00, 8'hFF, 4'd0}};
    // release delay edge
    dir_tab[14] = '{OP_SCAN,     8'h00, 16'd549,  8'h00, 1'b0, '0};
    dir_tab[15] = '{OP_SCAN,     8'h00, 16'd550,  8'h00, 1'b0, '0};
    dir_tab[16] = '{OP_POP,      8'h00, 16'h0000, 8'h00, 1'b0, '0};
    // time wrap and negative difference
    dir_tab[17] = '{OP_SCAN,     8'h80, 16'hFFF0, 8'h00, 1'b0, '0};
    dir_tab[18] = '{OP_SCAN,     8'h80, 16'h0200, 8'h00, 1'b0, '0};
    dir_tab[19] = '{OP_SCAN,     8'h80, 16'h8200, 8'h00, 1'b0, '0};
    dir_tab[20] = '{OP_SCAN,     8'h7F, 16'hFFFF, 8'h00, 1'b0, '0};
    // flush also clears the push-back slot
    dir_tab[21] = '{OP_PUSHBACK, 8'hFF, 16'hFFFF, 8'hAA, 1'b0, '0};
    dir_tab[22] = '{OP_FLUSH,    8'hFF, 16'hFFFF, 8'hFF, 1'b0, '0};
    dir_tab[23] = '{OP_POP,      8'hFF, 16'hFFFF, 8'hFF, 1'b0, '0};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIR_N; k++)
      offer_req(dir_tab[k].op, dir_tab[k].btn, dir_tab[k].tms, dir_tab[k].pb,
                dir_tab[k].typed, dir_tab[k].res);
    run_random(200, 1'b1);
    idle_until_drained();

    // zero interval and zero delays
    set_config(15'd0, 15'd0, 15'd0, 1'b1);
    run_random(180, 1'b0);
    idle_until_drained();

    snd_idle = 79;
    rcv_idle = 20;
    set_config(15'd32767, 15'd32767, 15'd32767, 1'b0);
    run_random(180, 1'b1);
    idle_until_drained();

    set_config(15'd0, 15'd1, 15'd32767, 1'b1);
    run_random(180, 1'b0);
    idle_until_drained();

    snd_idle = 0;
    rcv_idle = 0;
    set_config(15'($urandom_range(300)), 15'($urandom_range(120)), 15'($urandom_range(100)),
               1'b0);
    run_random(180, 1'b0);
    idle_until_drained();

    set_config(15'($urandom), 15'($urandom), 15'($urandom), 1'b1);
    run_random(180, 1'b0);
    idle_until_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
